// ----- src/derq_pkg.sv -----
// Shared types and constants for the double-ended ring queue unit.
`default_nettype none

package derq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Operation codes carried by an input transaction.
    typedef enum logic [2:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DRAIN      = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] push_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_data;
        logic        out_valid;
        logic        overflow;
        logic        last_of_run;
        logic [4:0]  fill_count;
        logic [31:0] back_data;
        logic        back_valid;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_BACK,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic back_rd;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drain_more;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- src/double_ended_ring_queue_unit.sv -----
// Top level of the double-ended ring queue unit: controller and datapath.
//
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-------------------------------
// input    | in        | i_in_valid / o_in_stall   | i_in_item  (operation, push_data)
// output   | out       | o_out_valid / i_out_stall | o_out_item (seven result fields)
//
// Each input transaction is accepted, then updates the indices and accesses
// the slot memory, then reads the back element through the second memory
// port, and then presents its result, which waits while the output is stalled.
// A drain repeats the access, back read and present sequence for each
// emitted word.
// Reset is synchronous and active low; it empties the queue without touching
// the slot memory. A stalled result holds its payload until it is taken.
`default_nettype none

module double_ended_ring_queue_unit #(
    parameter int DEPTH      = derq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = derq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire derq_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output derq_pkg::t_out_item    o_out_item
);
    import derq_pkg::*;

    // Commands flow from the controller to the datapath; the datapath only
    // reports whether a drain still has words to emit.
    t_dp_cmd  cmd;
    t_dp_stat stat;

    derq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // The datapath holds the slot memory, the head and tail indices, the
    // fill count, and the registers that form each result transaction.
    derq_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

// ----- src/derq_ctrl.sv -----
// Controller state machine of the double-ended ring queue unit.
`default_nettype none

module derq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output derq_pkg::t_dp_cmd      o_cmd,
    input  wire derq_pkg::t_dp_stat i_stat
);
    import derq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_BACK;
            end
            S_BACK: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = i_stat.drain_more ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        o_out_valid   = (r_state == S_OUT);
        o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.back_rd = (r_state == S_BACK);
    end

endmodule

`default_nettype wire

// ----- src/derq_dpath.sv -----
// Datapath of the double-ended ring queue unit: slot memory, indices and result assembly.
`default_nettype none

module derq_dpath #(
    parameter int DEPTH      = derq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = derq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire derq_pkg::t_in_item i_in_item,
    input  wire derq_pkg::t_dp_cmd i_cmd,
    output derq_pkg::t_dp_stat     o_stat,
    output derq_pkg::t_out_item    o_out_item
);
    import derq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    t_op                   r_op;
    logic [DATA_WIDTH-1:0] r_word;
    logic [IW-1:0]         r_head;
    logic [IW-1:0]         r_tail;
    logic [CW-1:0]         r_count;
    logic                  r_valid;
    logic                  r_ovf;
    logic                  r_last;
    logic [DATA_WIDTH-1:0] r_rd_a;
    logic [DATA_WIDTH-1:0] r_rd_b;

    logic [IW-1:0]         n_head;
    logic [IW-1:0]         n_tail;
    logic [CW-1:0]         n_count;
    logic                  n_valid;
    logic                  n_ovf;
    logic                  n_last;

    logic [IW-1:0]         head_next;
    logic [IW-1:0]         head_prev;
    logic [IW-1:0]         tail_next;
    logic [IW-1:0]         tail_prev;
    logic                  is_empty;
    logic                  is_full;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [63:0]           word_wide;
    logic [63:0]           rd_a_wide;
    logic [63:0]           rd_b_wide;

    assign head_next = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_prev = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_next = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_prev = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count >= FULL_CNT);
    assign word_wide = {32'd0, i_in_item.push_data};

    // One operation step: at most one slot write or one slot read.
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_valid = 1'b0;
        n_ovf   = 1'b0;
        n_last  = 1'b1;
        wr_en   = 1'b0;
        wr_addr = r_tail;
        rd_en   = 1'b0;
        rd_addr = r_head;
        unique case (r_op)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_ovf = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_op == OP_PUSH_BACK) begin
                        wr_addr = r_tail;
                        n_tail  = tail_next;
                    end else begin
                        wr_addr = head_prev;
                        n_head  = head_prev;
                    end
                end
            end
            OP_POP_FRONT, OP_DRAIN: begin
                if (!is_empty) begin
                    rd_en   = 1'b1;
                    rd_addr = r_head;
                    n_valid = 1'b1;
                    n_count = r_count - 1'b1;
                    n_head  = head_next;
                    n_last  = (r_op == OP_POP_FRONT) || (r_count == ONE_CNT);
                end
            end
            OP_POP_BACK: begin
                if (!is_empty) begin
                    rd_en   = 1'b1;
                    rd_addr = tail_prev;
                    n_valid = 1'b1;
                    n_count = r_count - 1'b1;
                    n_tail  = tail_prev;
                end
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
        // An emptied queue restarts at slot zero.
        if (n_count == '0) begin
            n_head = '0;
            n_tail = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_op    <= OP_PUSH_BACK;
            r_valid <= 1'b0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_op <= t_op'(i_in_item.operation);
            end
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_count <= n_count;
                r_valid <= n_valid;
                r_ovf   <= n_ovf;
                r_last  <= n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= word_wide[DATA_WIDTH-1:0];
        end
    end

    // Slot memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_addr] <= r_word;
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_a <= r_mem[rd_addr];
        end
        if (i_cmd.back_rd) begin
            r_rd_b <= r_mem[tail_prev];
        end
    end

    assign rd_a_wide = 64'(r_rd_a);
    assign rd_b_wide = 64'(r_rd_b);

    always_comb begin
        o_stat.drain_more      = (r_op == OP_DRAIN) && !is_empty;
        o_out_item.out_data    = r_valid ? rd_a_wide[31:0] : 32'd0;
        o_out_item.out_valid   = r_valid;
        o_out_item.overflow    = r_ovf;
        o_out_item.last_of_run = r_last;
        o_out_item.fill_count  = 5'(r_count);
        o_out_item.back_data   = is_empty ? 32'd0 : rd_b_wide[31:0];
        o_out_item.back_valid  = !is_empty;
    end

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the double-ended ring queue unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import derq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;

    // Operation codes the block does not define. They must still produce
    // one neutral result each.
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

    // Idling phases. Each one lasts a fixed number of input transactions,
    // and the phases rotate so that every one of them is visited more than once.
    localparam int PH_STEADY   = 0;
    localparam int PH_SENDER   = 1;
    localparam int PH_RECEIVER = 2;
    localparam int PH_BOTH     = 3;
    localparam int PHASE_ITEMS = 35;

    // Stimulus shapes for the random part.
    localparam int MODE_FILL  = 0;
    localparam int MODE_EMPTY = 1;
    localparam int MODE_MIXED = 2;

    localparam int RANDOM_ITEMS = 255;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 64;
    localparam int PRINT_CAP    = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Operations waiting to be driven, and the results the queue mirror
    // has predicted but the block has not yet delivered.
    t_in_item  op_backlog[$];
    t_out_item awaited_results[$];

    // Mirror of the queue contents and indices.
    logic [31:0] mirror_slots[QDEPTH];
    int          mirror_head = 0;
    int          mirror_tail = 0;
    int          mirror_count = 0;

    int accepted_ops = 0;
    int idle_phase = PH_STEADY;
    int idle_cycles = 0;
    int mismatches = 0;
    bit timed_out = 1'b0;

    double_ended_ring_queue_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Queue a result built from the current mirror state; the back element
    // and fill count always describe the queue after the operation.
    task automatic add_result(input logic [31:0] data, input logic valid,
                              input logic dropped, input logic last);
        t_out_item r;
        r.out_data    = valid ? data : '0;
        r.out_valid   = valid;
        r.overflow    = dropped;
        r.last_of_run = last;
        r.fill_count  = 5'(mirror_count);
        r.back_data   = (mirror_count != 0) ?
                        mirror_slots[(mirror_tail + QDEPTH - 1) % QDEPTH] : '0;
        r.back_valid  = (mirror_count != 0);
        awaited_results.push_back(r);
    endtask

    // Whenever the queue runs empty both indices snap back to slot zero.
    function automatic void rewind_if_empty();
        if (mirror_count == 0) begin
            mirror_head = 0;
            mirror_tail = 0;
        end
    endfunction

    function automatic logic [31:0] take_front_word();
        logic [31:0] w;
        w = mirror_slots[mirror_head];
        mirror_head = (mirror_head + 1) % QDEPTH;
        mirror_count--;
        rewind_if_empty();
        return w;
    endfunction

    // Apply one accepted operation to the mirror and predict its results.
    task automatic mirror_queue_op(input t_in_item op_item);
        logic [31:0] w;
        case (op_item.operation)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
                if (mirror_count >= QDEPTH) begin
                    add_result('0, 1'b0, 1'b1, 1'b1);
                end else begin
                    if (op_item.operation == OP_PUSH_BACK) begin
                        mirror_slots[mirror_tail] = op_item.push_data;
                        mirror_tail = (mirror_tail + 1) % QDEPTH;
                    end else begin
                        mirror_head = (mirror_head + QDEPTH - 1) % QDEPTH;
                        mirror_slots[mirror_head] = op_item.push_data;
                    end
                    mirror_count++;
                    add_result('0, 1'b0, 1'b0, 1'b1);
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (mirror_count == 0) begin
                    add_result('0, 1'b0, 1'b0, 1'b1);
                end else begin
                    if (op_item.operation == OP_POP_FRONT) begin
                        w = take_front_word();
                    end else begin
                        mirror_tail = (mirror_tail + QDEPTH - 1) % QDEPTH;
                        w = mirror_slots[mirror_tail];
                        mirror_count--;
                        rewind_if_empty();
                    end
                    add_result(w, 1'b1, 1'b0, 1'b1);
                end
            end
            OP_DRAIN: begin
                // An empty drain still answers once, with nothing removed.
                if (mirror_count == 0) begin
                    add_result('0, 1'b0, 1'b0, 1'b1);
                end else begin
                    while (mirror_count != 0) begin
                        w = take_front_word();
                        add_result(w, 1'b1, 1'b0, mirror_count == 0);
                    end
                end
            end
            default: begin
                add_result('0, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endtask

    function automatic bit sender_idles(input int phase);
        return (phase == PH_SENDER || phase == PH_BOTH) &&
               ($urandom_range(99) < ((phase == PH_BOTH) ? 17 : 49));
    endfunction

    function automatic bit receiver_stalls(input int phase);
        return (phase == PH_RECEIVER || phase == PH_BOTH) &&
               ($urandom_range(99) < ((phase == PH_BOTH) ? 17 : 49));
    endfunction

    // Driver: presents the next backlog entry once the previous transaction
    // has been taken, and hands every accepted operation to the mirror.
    always @(posedge clk) begin : drive_ops
        logic     next_valid;
        t_in_item next_item;
        next_valid = in_valid;
        next_item  = in_item;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                mirror_queue_op(in_item);
                accepted_ops++;
                next_valid = 1'b0;
            end
            if (!next_valid && op_backlog.size() != 0 && !sender_idles(idle_phase)) begin
                next_item  = op_backlog.pop_front();
                next_valid = 1'b1;
            end
        end
        in_valid   <= next_valid;
        in_item    <= next_item;
        idle_phase <= (accepted_ops / PHASE_ITEMS) % 4;
    end

    // Monitor: every result taken from the block is checked field by field
    // against the oldest prediction.
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (awaited_results.size() == 0) begin
                note_mismatch("unexpected result, out_data", out_item.out_data, '0);
            end else begin
                want = awaited_results.pop_front();
                if (out_item.out_data !== want.out_data)
                    note_mismatch("out_data", out_item.out_data, want.out_data);
                if (out_item.out_valid !== want.out_valid)
                    note_mismatch("out_valid", 32'(out_item.out_valid), 32'(want.out_valid));
                if (out_item.overflow !== want.overflow)
                    note_mismatch("overflow", 32'(out_item.overflow), 32'(want.overflow));
                if (out_item.last_of_run !== want.last_of_run)
                    note_mismatch("last_of_run", 32'(out_item.last_of_run),
                                  32'(want.last_of_run));
                if (out_item.fill_count !== want.fill_count)
                    note_mismatch("fill_count", 32'(out_item.fill_count),
                                  32'(want.fill_count));
                if (out_item.back_data !== want.back_data)
                    note_mismatch("back_data", out_item.back_data, want.back_data);
                if (out_item.back_valid !== want.back_valid)
                    note_mismatch("back_valid", 32'(out_item.back_valid),
                                  32'(want.back_valid));
            end
        end
        out_stall <= rst_n && receiver_stalls(idle_phase);
    end

    // Watchdog: any cycle without a transaction on either channel counts
    // toward the limit.
    always @(posedge clk) begin : watch_progress
        if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            timed_out <= 1'b1;
        end
    end

    task automatic queue_op(input logic [2:0] op, input logic [31:0] data);
        t_in_item it;
        it.operation = op;
        it.push_data = data;
        op_backlog.push_back(it);
    endtask

    // Mostly random words, with the all-zero and all-one extremes mixed in.
    function automatic logic [31:0] random_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] random_op(input int mode);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(99);
        push_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_EMPTY) ? 30 : 45;
        pop_pct  = (mode == MODE_FILL) ? 90 : (mode == MODE_EMPTY) ? 85 : 80;
        if (r < push_pct)
            return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < pop_pct)
            return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        if (r < 96)
            return OP_DRAIN;
        return 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
    endfunction

    initial begin : run_test
        int left;
        int mode;
        int run;

        // Directed part: every operation on an empty queue, the reserved
        // codes, a fill from both ends up to capacity, pushes into the full
        // queue, and a drain of the full queue.
        queue_op(OP_POP_FRONT, '1);
        queue_op(OP_POP_BACK, '0);
        queue_op(OP_DRAIN, '0);
        for (int c = OP_RESERVED_FIRST; c <= OP_RESERVED_LAST; c++) begin
            queue_op(3'(c), $urandom);
        end
        queue_op(OP_PUSH_BACK, '0);
        queue_op(OP_PUSH_FRONT, '1);
        for (int i = 2; i < QDEPTH; i++) begin
            queue_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                     (i % 2) ? (32'hA5A5_0000 | 32'(i)) : ~(32'h1 << i));
        end
        queue_op(OP_PUSH_BACK, 32'hDEAD_0001);
        queue_op(OP_PUSH_FRONT, 32'hDEAD_0002);
        queue_op(OP_DRAIN, '0);

        // Random part: runs that lean toward filling, toward emptying, or
        // neither, so the queue often swings between empty and full.
        left = RANDOM_ITEMS;
        while (left > 0) begin
            mode = $urandom_range(MODE_FILL, MODE_MIXED);
            run  = $urandom_range(10, 30);
            for (int k = 0; k < run && left > 0; k++) begin
                queue_op(random_op(mode), random_word());
                left--;
            end
        end

        // Wait until every transaction was taken and every result arrived,
        // then leave room for any stray result before judging the run.
        while (!timed_out &&
               (op_backlog.size() != 0 || in_valid || awaited_results.size() != 0)) begin
            @(negedge clk);
        end
        if (!timed_out) begin
            repeat (TAIL_CYCLES) @(negedge clk);
        end
        if (awaited_results.size() != 0) begin
            note_mismatch("results never delivered", '0, 32'(awaited_results.size()));
        end
        if (!timed_out && mismatches == 0) begin
            $display("[double_ended_ring_queue_unit] OK");
        end else begin
            $display("[double_ended_ring_queue_unit] ERROR");
        end
        $finish;
    end

endmodule

// ----- double_ended_ring_queue_unit.f -----
src/derq_pkg.sv
src/derq_ctrl.sv
src/derq_dpath.sv
src/double_ended_ring_queue_unit.sv
dv/tb.sv
